>>> rtl/bb3_pkg.sv
// Shared types, constants and helper functions for the 3x3 edge-normalized box blur.
`timescale 1ns / 1ps
package bb3_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int CH_W        = 8;
  localparam int SUM_W       = 12;   // up to 9 * 255
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 15;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic            operation;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            out_last;
  } out_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  localparam int PIX_W = $bits(pix_t);

  typedef struct packed {
    logic       shift;
    logic       sum_en;
    logic       mul_en;
    logic [2:0] rmask;   // window rows inside the frame
    logic [2:0] cmask;   // window columns inside the frame
  } win_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_SUM,
    ST_MUL,
    ST_OUT
  } state_t;

  // 0 acts as 1, anything above the maximum acts as the maximum
  function automatic int clamp_dim(int v, int max_v);
    int res;
    res = v;
    if (v == 0) begin
      res = 1;
    end else if (v > max_v) begin
      res = max_v;
    end
    return res;
  endfunction

  // ceil(2^15 / n); exact floor division for sums up to 9 * 255
  function automatic logic [RECIP_W-1:0] recip(logic [3:0] n);
    logic [RECIP_W-1:0] m;
    unique case (n)
      4'd2:    m = 16'd16384;
      4'd3:    m = 16'd10923;
      4'd4:    m = 16'd8192;
      4'd5:    m = 16'd6554;
      4'd6:    m = 16'd5462;
      4'd7:    m = 16'd4682;
      4'd8:    m = 16'd4096;
      4'd9:    m = 16'd3641;
      default: m = 16'd32768;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/bb3_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module bb3_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/bb3_window.sv
// 3x3 neighbourhood window with masked channel sums and reciprocal-multiply mean.
`timescale 1ns / 1ps
module bb3_window (
  input  logic                  clk,
  input  bb3_pkg::win_ctrl_t    ctl,
  input  bb3_pkg::pix_t         top_px,
  input  bb3_pkg::pix_t         mid_px,
  input  bb3_pkg::pix_t         bot_px,
  output bb3_pkg::pix_t         mean
);

  bb3_pkg::pix_t                       win_r [3][3];
  logic [2:0]                          rmask_r;
  logic [2:0]                          cmask_r;
  logic [bb3_pkg::SUM_W-1:0]           sum_r [3];
  logic [bb3_pkg::RECIP_W-1:0]         recip_r;
  logic [bb3_pkg::PROD_W-1:0]          prod_r [3];

  logic [bb3_pkg::SUM_W-1:0]           sum_nxt [3];
  logic [1:0]                          nr;
  logic [1:0]                          nc;
  logic [3:0]                          n_cnt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_nxt[k] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (rmask_r[i] && cmask_r[j]) begin
          sum_nxt[0] = sum_nxt[0] + bb3_pkg::SUM_W'(win_r[i][j].red);
          sum_nxt[1] = sum_nxt[1] + bb3_pkg::SUM_W'(win_r[i][j].green);
          sum_nxt[2] = sum_nxt[2] + bb3_pkg::SUM_W'(win_r[i][j].blue);
        end
      end
    end
    nr    = {1'b0, rmask_r[0]} + {1'b0, rmask_r[1]} + {1'b0, rmask_r[2]};
    nc    = {1'b0, cmask_r[0]} + {1'b0, cmask_r[1]} + {1'b0, cmask_r[2]};
    n_cnt = {2'b00, nr} * {2'b00, nc};
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= top_px;
      win_r[1][2] <= mid_px;
      win_r[2][2] <= bot_px;
      rmask_r     <= ctl.rmask;
      cmask_r     <= ctl.cmask;
    end
    if (ctl.sum_en) begin
      for (int k = 0; k < 3; k++) begin
        sum_r[k] <= sum_nxt[k];
      end
      recip_r <= bb3_pkg::recip(n_cnt);
    end
    if (ctl.mul_en) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= {{bb3_pkg::RECIP_W{1'b0}}, sum_r[k]} *
                     {{bb3_pkg::SUM_W{1'b0}}, recip_r};
      end
    end
  end

  assign mean.red   = prod_r[0][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];
  assign mean.green = prod_r[1][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];
  assign mean.blue  = prod_r[2][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];

endmodule

>>> rtl/box_blur_3x3_edge_normalized.sv
// 3x3 box blur over RGB888 raster pixels; each channel is the truncated mean of the
// in-frame neighbours (1 to 9 of them). Results trail the input by one row plus one
// pixel; after the last pixel of a frame, flush beats drain the rest, and the final
// result carries out_last. Pixel items arriving while a flush is pending are dropped,
// as are flush beats with no frame pending. The block works on one item at a time,
// sequenced around a single 48-bit row-store RAM (read, written back the next cycle):
// a result-yielding item goes through transfer, window update and row-store write,
// sum, multiply and output load, one that yields none through the first two, a dropped
// item through transfer only; the first flush beat of a one-row frame takes two window
// steps. A result waiting on out_ready stalls only the output load. Writing frame_width
// or frame_height restarts the frame position; there is no memory clearing after reset.
`timescale 1ns / 1ps
module box_blur_3x3_edge_normalized #(
  parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bb3_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bb3_pkg::out_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 2);
  localparam int RXW   = RW + 1;
  localparam logic [WW-1:0] W_RST =
    WW'(bb3_pkg::clamp_dim(bb3_pkg::FRAME_WIDTH_RST, MAX_WIDTH));
  localparam logic [HW-1:0] H_RST =
    HW'(bb3_pkg::clamp_dim(bb3_pkg::FRAME_HEIGHT_RST, MAX_HEIGHT));

  bb3_pkg::state_t      state_r, state_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic                 complete_r, complete_nxt;
  logic [WW-1:0]        eff_w_r, eff_w_nxt;
  logic [HW-1:0]        eff_h_r, eff_h_nxt;
  bb3_pkg::pix_t        pix_r, pix_nxt;
  logic                 flush_r, flush_nxt;
  logic                 was_last_r, was_last_nxt;
  logic                 last_r, last_nxt;
  logic                 out_valid_r, out_valid_nxt;
  bb3_pkg::out_t        out_data_r, out_data_nxt;

  logic                 ram_rd_en;
  logic                 ram_wr_en;
  logic [2*bb3_pkg::PIX_W-1:0] ram_rd_data;
  bb3_pkg::pix_t        older_px;
  bb3_pkg::pix_t        prev_px;
  bb3_pkg::win_ctrl_t   ctl;
  bb3_pkg::pix_t        mean;

  logic [RXW-1:0]       rx;
  logic [RXW-1:0]       hx;
  logic [WW-1:0]        c_inc;
  logic                 c_zero;
  logic                 c_wrap;
  logic                 c_ge2;
  logic                 r_last;
  logic                 produce;
  logic                 take;
  logic                 out_load;

  assign older_px = ram_rd_data[2*bb3_pkg::PIX_W-1:bb3_pkg::PIX_W];
  assign prev_px  = ram_rd_data[bb3_pkg::PIX_W-1:0];

  bb3_ram #(
    .WIDTH  (2 * bb3_pkg::PIX_W),
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (col_r),
    .wr_data ({prev_px, pix_r}),
    .rd_en   (ram_rd_en),
    .rd_addr (col_r),
    .rd_data (ram_rd_data)
  );

  bb3_window u_window (
    .clk    (clk),
    .ctl    (ctl),
    .top_px (older_px),
    .mid_px (prev_px),
    .bot_px (pix_r),
    .mean   (mean)
  );

  assign rx      = RXW'(row_r);
  assign hx      = RXW'(eff_h_r);
  assign c_inc   = WW'(col_r) + WW'(1);
  assign c_zero  = (col_r == '0);
  assign c_wrap  = (c_inc == eff_w_r);
  assign c_ge2   = !c_zero && (col_r != COL_W'(1));
  assign r_last  = ((rx + RXW'(1)) == hx);
  assign produce = (rx >= RXW'(2)) || ((rx == RXW'(1)) && !c_zero);
  assign take    = ((in_data.operation == bb3_pkg::OP_PIXEL) && !complete_r) ||
                   ((in_data.operation == bb3_pkg::OP_FLUSH) && complete_r);
  assign out_load = (state_r == bb3_pkg::ST_OUT) && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    complete_nxt  = complete_r;
    eff_w_nxt     = eff_w_r;
    eff_h_nxt     = eff_h_r;
    pix_nxt       = pix_r;
    flush_nxt     = flush_r;
    was_last_nxt  = was_last_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    ram_rd_en     = 1'b0;
    ram_wr_en     = 1'b0;
    ctl           = '0;

    unique case (state_r)
      bb3_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && take) begin
          if (in_data.operation == bb3_pkg::OP_FLUSH) begin
            pix_nxt = '0;
          end else begin
            pix_nxt = '{red: in_data.in_red, green: in_data.in_green,
                        blue: in_data.in_blue};
          end
          flush_nxt    = (in_data.operation == bb3_pkg::OP_FLUSH);
          was_last_nxt = (in_data.operation == bb3_pkg::OP_PIXEL) && r_last && c_wrap;
          ram_rd_en    = 1'b1;
          state_nxt    = bb3_pkg::ST_SHIFT;
        end
      end
      bb3_pkg::ST_READ: begin
        ram_rd_en = 1'b1;
        state_nxt = bb3_pkg::ST_SHIFT;
      end
      bb3_pkg::ST_SHIFT: begin
        ctl.shift = 1'b1;
        ram_wr_en = 1'b1;
        // window is taken after the shift; at column 0 it centers on the row's end
        if (c_zero) begin
          ctl.rmask = {rx <= hx, rx <= hx + RXW'(1), rx >= RXW'(3)};
          ctl.cmask = {1'b0, 1'b1, eff_w_r != WW'(1)};
          last_nxt  = (rx == hx + RXW'(1));
        end else begin
          ctl.rmask = {rx < hx, rx <= hx, rx >= RXW'(2)};
          ctl.cmask = {1'b1, 1'b1, c_ge2};
          last_nxt  = 1'b0;
        end
        if (c_wrap) begin
          col_nxt = '0;
          row_nxt = row_r + RW'(1);
        end else begin
          col_nxt = COL_W'(c_inc);
        end
        if (was_last_r) begin
          complete_nxt = 1'b1;
        end
        priority if (produce) begin
          state_nxt = bb3_pkg::ST_SUM;
        end else if (flush_r) begin
          state_nxt = bb3_pkg::ST_READ;
        end else begin
          state_nxt = bb3_pkg::ST_IDLE;
        end
      end
      bb3_pkg::ST_SUM: begin
        ctl.sum_en = 1'b1;
        state_nxt  = bb3_pkg::ST_MUL;
      end
      bb3_pkg::ST_MUL: begin
        ctl.mul_en = 1'b1;
        state_nxt  = bb3_pkg::ST_OUT;
      end
      bb3_pkg::ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_red: mean.red, out_green: mean.green,
                            out_blue: mean.blue, out_last: last_r};
          if (last_r) begin
            row_nxt      = '0;
            col_nxt      = '0;
            complete_nxt = 1'b0;
          end
          state_nxt = bb3_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bb3_pkg::ST_IDLE;
      end
    endcase

    // register writes restart the frame position
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == bb3_pkg::REG_FRAME_WIDTH) begin
        eff_w_nxt    = WW'(bb3_pkg::clamp_dim(int'(cfg_data), MAX_WIDTH));
        row_nxt      = '0;
        col_nxt      = '0;
        complete_nxt = 1'b0;
      end else if (cfg_index == bb3_pkg::REG_FRAME_HEIGHT) begin
        eff_h_nxt    = HW'(bb3_pkg::clamp_dim(int'(cfg_data), MAX_HEIGHT));
        row_nxt      = '0;
        col_nxt      = '0;
        complete_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bb3_pkg::ST_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      complete_r  <= 1'b0;
      eff_w_r     <= W_RST;
      eff_h_r     <= H_RST;
      flush_r     <= 1'b0;
      was_last_r  <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      complete_r  <= complete_nxt;
      eff_w_r     <= eff_w_nxt;
      eff_h_r     <= eff_h_nxt;
      flush_r     <= flush_nxt;
      was_last_r  <= was_last_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r      <= pix_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_r) |=> (row_r == '0 && col_r == '0 && !complete_r))
    else $error("frame position not restarted after last result");

  a_pending_past_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (complete_r && state_r == bb3_pkg::ST_IDLE) |-> (rx >= hx))
    else $error("flush pending while input row still inside frame");

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> (WW'(col_r) < eff_w_r))
    else $error("input column beyond frame width");

endmodule

>>> test/box_blur_3x3_edge_normalized_tb.sv
// Self-checking testbench for the 3x3 box blur: directed, pressure and random frames.
`timescale 1ns / 1ps
module box_blur_3x3_edge_normalized_tb;
  import bb3_pkg::*;

  localparam int SETTLE_CYCLES = 10;
  localparam int QUIET_LIMIT   = 1000;
  localparam int RANDOM_ITEMS  = 800;
  localparam int SINK_HOLD     = 150;
  localparam int CLAMP_PIXELS  = 40;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  box_blur_3x3_edge_normalized DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------- blur predictor ----------------
  pix_t                  prev_row_mem  [MAX_WIDTH_DEF];
  pix_t                  older_row_mem [MAX_WIDTH_DEF];
  pix_t                  win [3][3];
  int                    in_row;
  int                    in_col;
  bit                    frame_done;
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  out_t                  expected_pixels [$];
  int                    taken_items;

  int mismatch_count;
  int quiet_cycles;
  bit src_burst;
  bit sink_burst;
  int sink_hold;

  function automatic int active_dim(int v, int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic void restart_position();
    in_row     = 0;
    in_col     = 0;
    frame_done = 1'b0;
  endfunction

  function automatic void blur_reset_model();
    foreach (prev_row_mem[i]) begin
      prev_row_mem[i]  = '0;
      older_row_mem[i] = '0;
    end
    foreach (win[i, j]) win[i][j] = '0;
    width_reg   = FRAME_WIDTH_RST;
    height_reg  = FRAME_HEIGHT_RST;
    taken_items = 0;
    restart_position();
  endfunction

  // window row i is frame row orow-1+i, window column j is frame column base+j
  function automatic out_t neighbourhood_mean(int orow, int ocol, int base, int w, int h);
    int   sr, sg, sb, cnt, row, col;
    out_t res;
    sr  = 0;
    sg  = 0;
    sb  = 0;
    cnt = 0;
    for (int i = 0; i < 3; i++) begin
      row = orow - 1 + i;
      if (row >= 0 && row < h) begin
        for (int j = 0; j < 3; j++) begin
          col = base + j;
          if (col >= ocol - 1 && col <= ocol + 1 && col >= 0 && col < w) begin
            sr += win[i][j].red;
            sg += win[i][j].green;
            sb += win[i][j].blue;
            cnt++;
          end
        end
      end
    end
    if (cnt == 0) cnt = 1;
    res.out_red   = CH_W'(sr / cnt);
    res.out_green = CH_W'(sg / cnt);
    res.out_blue  = CH_W'(sb / cnt);
    res.out_last  = (orow == h - 1) && (ocol == w - 1);
    return res;
  endfunction

  function automatic bit blur_advance(pix_t px, output out_t res);
    int w, h, r, c, col;
    bit produce;
    w   = active_dim(width_reg, MAX_WIDTH_DEF);
    h   = active_dim(height_reg, MAX_HEIGHT_DEF);
    r   = in_row;
    c   = in_col;
    res = '0;
    produce = (r >= 2) || (r == 1 && c >= 1);
    // row wrap: the last pixel of the previous row is finished before the shift
    if (produce && c == 0) res = neighbourhood_mean(r - 2, w - 1, w - 3, w, h);
    col = (c >= MAX_WIDTH_DEF) ? 0 : c;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = older_row_mem[col];
    win[1][2] = prev_row_mem[col];
    win[2][2] = px;
    older_row_mem[col] = prev_row_mem[col];
    prev_row_mem[col]  = px;
    if (produce && c != 0) res = neighbourhood_mean(r - 1, c - 1, c - 2, w, h);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    in_row = r;
    in_col = c;
    return produce;
  endfunction

  function automatic void blur_predict(in_t item);
    out_t res;
    bit   got, is_last;
    int   w, h;
    w = active_dim(width_reg, MAX_WIDTH_DEF);
    h = active_dim(height_reg, MAX_HEIGHT_DEF);
    if (item.operation == OP_PIXEL) begin
      if (!frame_done) begin
        is_last = (in_row == h - 1) && (in_col == w - 1);
        if (blur_advance({item.in_red, item.in_green, item.in_blue}, res)) begin
          expected_pixels.push_back(res);
        end
        if (is_last) frame_done = 1'b1;
        taken_items++;
      end
    end else if (frame_done) begin
      got = blur_advance('0, res);
      if (!got) got = blur_advance('0, res);
      taken_items++;
      if (got) begin
        expected_pixels.push_back(res);
        if (res.out_last) restart_position();
      end
    end
  endfunction

  // ---------------- drivers ----------------
  task automatic send_item(in_t item);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    blur_predict(item);
  endtask

  function automatic pix_t random_pixel();
    pix_t p;
    logic [CH_W-1:0] ch [3];
    foreach (ch[i]) begin
      case ($urandom_range(0, 7))
        0:       ch[i] = '0;
        1:       ch[i] = '1;
        default: ch[i] = CH_W'($urandom_range(0, 255));
      endcase
    end
    p.red   = ch[0];
    p.green = ch[1];
    p.blue  = ch[2];
    return p;
  endfunction

  task automatic send_pixel(pix_t p);
    in_t item;
    item.operation = OP_PIXEL;
    item.in_red    = p.red;
    item.in_green  = p.green;
    item.in_blue   = p.blue;
    send_item(item);
  endtask

  // flush payload is don't-care, so it carries random bits
  task automatic send_flush();
    in_t  item;
    pix_t p;
    p = random_pixel();
    item.operation = OP_FLUSH;
    item.in_red    = p.red;
    item.in_green  = p.green;
    item.in_blue   = p.blue;
    send_item(item);
  endtask

  task automatic flush_frame();
    while (frame_done) send_flush();
  endtask

  task automatic write_frame(int w, int h);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    width_reg = CFG_DATA_W'(w);
    restart_position();
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    height_reg = CFG_DATA_W'(h);
    restart_position();
    cfg_valid <= 1'b0;
  endtask

  // block must be idle before a register write
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------- result side ----------------
  initial begin : result_sink
    int stall, hold;
    @(posedge clk);
    forever begin
      stall = sink_burst ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      if (sink_hold > 0) begin
        hold      = sink_hold;
        sink_hold = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic report_mismatch(string what);
    if (mismatch_count < 50) $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.out_red !== want.out_red)
          report_mismatch($sformatf("red %0d, expected %0d", out_data.out_red, want.out_red));
        if (out_data.out_green !== want.out_green)
          report_mismatch($sformatf("green %0d, expected %0d",
                                    out_data.out_green, want.out_green));
        if (out_data.out_blue !== want.out_blue)
          report_mismatch($sformatf("blue %0d, expected %0d", out_data.out_blue, want.out_blue));
        if (out_data.out_last !== want.out_last)
          report_mismatch($sformatf("last %b, expected %b", out_data.out_last, want.out_last));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < QUIET_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_directed_edges();
    pix_t pat [6];
    drain_results();
    write_frame(3, 2);
    send_flush();                    // no frame pending: dropped
    pat = '{24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FF00, 24'hFFFFFF, 24'h01807F};
    foreach (pat[i]) send_pixel(pat[i]);
    send_pixel(24'hA5A5A5);          // flush pending: dropped
    flush_frame();
    send_flush();                    // frame already closed: dropped
    drain_results();
    write_frame(0, 0);               // both act as 1
    send_pixel(24'h123456);
    send_pixel(24'hFEDCBA);
    flush_frame();
  endtask

  task automatic test_restart_mid_frame();
    drain_results();
    write_frame(3, 3);
    repeat (5) send_pixel(random_pixel());
    drain_results();
    write_frame(1, 2);               // abandons the partial frame
    repeat (2) send_pixel(random_pixel());
    flush_frame();
  endtask

  task automatic test_backpressure();
    drain_results();
    write_frame(6, 5);
    src_burst = 1'b1;
    sink_hold = SINK_HOLD;
    repeat (18) send_pixel(random_pixel());
    drain_results();                 // sender waits for every result mid-frame
    repeat (12) send_pixel(random_pixel());
    flush_frame();
    src_burst = 1'b0;
  endtask

  task automatic test_random_frames();
    int start, w, h, npix, pick;
    start = taken_items;
    while (taken_items - start < RANDOM_ITEMS) begin
      src_burst  = ($urandom_range(0, 3) == 0);
      sink_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      w = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = (pick == 2) ? 0 : $urandom_range(1, 8);
      drain_results();
      write_frame(w, h);
      npix = active_dim(w, MAX_WIDTH_DEF) * active_dim(h, MAX_HEIGHT_DEF);
      if ($urandom_range(0, 9) == 0) npix = $urandom_range(0, npix - 1);  // cut short
      for (int i = 0; i < npix; i++) begin
        if ($urandom_range(0, 19) == 0) send_flush();
        send_pixel(random_pixel());
      end
      if (frame_done) begin
        if ($urandom_range(0, 3) == 0) send_pixel(random_pixel());
        flush_frame();
        if ($urandom_range(0, 3) == 0) send_flush();
      end
    end
    src_burst  = 1'b0;
    sink_burst = 1'b0;
  endtask

  // oversized dimensions on partial frames: the clamped width leaves the first
  // rows without results, the clamped height keeps a one-column frame open
  task automatic test_largest_frames();
    drain_results();
    write_frame(2047, 2047);         // clamps to the widest row
    repeat (CLAMP_PIXELS) send_pixel(random_pixel());
    drain_results();
    write_frame(1, 2047);            // one column, tallest frame
    repeat (CLAMP_PIXELS) send_pixel(random_pixel());
  endtask

  initial begin : test_sequence
    mismatch_count = 0;
    quiet_cycles   = 0;
    src_burst      = 1'b0;
    sink_burst     = 1'b0;
    sink_hold      = 0;
    blur_reset_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_restart_mid_frame();
    test_backpressure();
    test_random_frames();
    test_largest_frames();
    drain_results();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
